[rtl/longest_prefix_route_table_unit_assert.svh]
// ---------------------------------------------------------------------------
// route table assertion macros
// shorthand for clocked implications on clk with rst_n as disable
// ---------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_ROUTE_TABLE_UNIT_ASSERT_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define LPRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define LPRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lprt_pkg.sv]
// ---------------------------------------------------------------------------
// lprt_pkg
// shared types, codes and helpers of the route table
// ---------------------------------------------------------------------------
package lprt_pkg;

  localparam int TableSize = 16;
  localparam int CntW      = $clog2(TableSize + 1);
  localparam int PlenW     = 6;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DEL    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NODEV    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_UNREACH  = 3'd4;

  localparam logic [31:0] BcastAddr = 32'hFFFF_FFFF;

  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [3:0]  dev;
  } req_t;

  typedef struct packed {
    logic [31:0]      dest;
    logic [31:0]      mask;
    logic [31:0]      gw;
    logic [3:0]       dev;
    logic [PlenW-1:0] plen;
  } ent_t;

  typedef struct packed {
    logic             tok;
    logic             hit;
    logic [PlenW-1:0] best_len;
    logic [31:0]      best_gw;
    logic [3:0]       best_dev;
  } cand_t;

  // number of leading one bits of a mask
  function automatic logic [PlenW-1:0] lead_ones(input logic [31:0] m);
    logic [PlenW-1:0] n;
    n = PlenW'(32);
    for (int i = 0; i < 32; i++) begin
      if (!m[i]) begin
        n = PlenW'(31 - i);
      end
    end
    return n;
  endfunction

endpackage

[rtl/lprt_cell.sv]
// ---------------------------------------------------------------------------
// lprt_cell
// one route slot: holds an entry, evaluates the passing item and hands
// the running search state to the next cell
// ---------------------------------------------------------------------------
module lprt_cell import lprt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  req_t  req,
  input  logic  occ,
  input  logic  wr_sel,
  input  cand_t cand_i,
  output cand_t cand_o,
  input  ent_t  ent_i,
  input  logic  shift_i,
  output ent_t  ent_o,
  output logic  shift_o
);

  ent_t  ent_r, ent_nxt;
  cand_t cand_r, cand_nxt;
  logic  dev_ok, del_match, lkp_match;

  always_comb begin
    dev_ok    = (req.dev == 4'd0) || (ent_r.dev == req.dev);
    del_match = occ && !cand_i.hit && (ent_r.dest == req.addr) &&
                ((req.mask == 32'd0) || (ent_r.mask == req.mask)) &&
                ((req.gw == 32'd0) || (ent_r.gw == req.gw)) && dev_ok;
    lkp_match = occ && ((req.addr & ent_r.mask) == ent_r.dest) && dev_ok &&
                (!cand_i.hit || (ent_r.plen > cand_i.best_len));
    cand_nxt  = cand_i;
    ent_nxt   = ent_r;
    shift_o   = 1'b0;
    if (cand_i.tok) begin
      case (req.op)
        OP_ADD: begin
          if (wr_sel && (req.dev != 4'd0)) begin
            ent_nxt.dest = req.addr;
            ent_nxt.mask = req.mask;
            ent_nxt.gw   = req.gw;
            ent_nxt.dev  = req.dev;
            ent_nxt.plen = lead_ones(req.mask);
          end
        end
        OP_DEL: begin
          // entries after the removed one move down one slot
          if (cand_i.hit) begin
            shift_o = 1'b1;
          end else if (del_match) begin
            cand_nxt.hit = 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (lkp_match) begin
            cand_nxt.hit      = 1'b1;
            cand_nxt.best_len = ent_r.plen;
            cand_nxt.best_gw  = ent_r.gw;
            cand_nxt.best_dev = ent_r.dev;
          end
        end
        default: begin
        end
      endcase
    end
    if (shift_i) begin
      ent_nxt = ent_i;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r.tok <= 1'b0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  assign cand_o = cand_r;
  assign ent_o  = ent_r;

endmodule

[rtl/longest_prefix_route_table_unit.sv]
// ---------------------------------------------------------------------------
// longest_prefix_route_table_unit
// ipv4 route table with add, delete and longest-prefix next-hop lookup
// ---------------------------------------------------------------------------
// The table is a row of TableSize cells, one route per cell, kept packed in
// insertion order. An accepted item walks the row one cell per cycle, and
// each cell updates the running search state it hands on: adds are written
// into the first free cell, deletes pull later entries down one cell, and
// lookups keep the longest prefix seen so far. No new item is taken until
// the walk through the cell row is done and its result is placed in the
// output register, or, while the output stalls, in a pending register
// until the output drains; the result is held in the output register
// while the next item is taken.
module longest_prefix_route_table_unit import lprt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_address,
  input  logic [31:0] in_prefix_mask,
  input  logic [31:0] in_gateway,
  input  logic [3:0]  in_device,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_next_hop,
  output logic [3:0]  out_device
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN} state_t;

  state_t           state_r;
  req_t             req_r;
  logic             start_r;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             out_valid_r;
  logic [2:0]       out_status_r, pend_status_r, res_status;
  logic [31:0]      out_hop_r, pend_hop_r, res_hop;
  logic [3:0]       out_dev_r, pend_dev_r, res_dev;

  cand_t            cand_w  [TableSize+1];
  ent_t             ent_w   [TableSize+1];
  logic             shift_w [TableSize+1];
  logic             done;
  cand_t            fin;

  assign cand_w[0]          = '{tok: start_r, hit: 1'b0, best_len: '0,
                                best_gw: '0, best_dev: '0};
  assign ent_w[TableSize]   = '0;
  assign shift_w[TableSize] = 1'b0;

  for (genvar j = 0; j < TableSize; j++) begin : g_cell
    lprt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req_r),
      .occ     (CntW'(j) < count_r),
      .wr_sel  (CntW'(j) == count_r),
      .cand_i  (cand_w[j]),
      .cand_o  (cand_w[j+1]),
      .ent_i   (ent_w[j+1]),
      .shift_i (shift_w[j+1]),
      .ent_o   (ent_w[j]),
      .shift_o (shift_w[j])
    );
  end

  assign fin  = cand_w[TableSize];
  assign done = fin.tok;

  always_comb begin
    res_status = ST_OK;
    res_hop    = 32'd0;
    res_dev    = 4'd0;
    count_nxt  = count_r;
    case (req_r.op)
      OP_ADD: begin
        if (req_r.dev == 4'd0) begin
          res_status = ST_NODEV;
        end else if (count_r == CntW'(TableSize)) begin
          res_status = ST_FULL;
        end else begin
          count_nxt = count_r + CntW'(1);
        end
      end
      OP_DEL: begin
        if (fin.hit) begin
          count_nxt = count_r - CntW'(1);
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      OP_LOOKUP: begin
        if (req_r.addr == BcastAddr) begin
          res_hop = req_r.addr;
        end else if (fin.hit) begin
          res_hop = (fin.best_gw == 32'd0) ? req_r.addr : fin.best_gw;
          res_dev = fin.best_dev;
        end else begin
          res_status = ST_UNREACH;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= (state_r == S_IDLE) && in_valid;
      unique case (state_r)
        S_IDLE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (in_valid) begin
            req_r.op   <= op_t'(in_operation);
            req_r.addr <= in_address;
            req_r.mask <= in_prefix_mask;
            req_r.gw   <= in_gateway;
            req_r.dev  <= in_device;
            state_r    <= S_WALK;
          end
        end
        S_WALK: begin
          if (done) begin
            count_r <= count_nxt;
            if (!out_valid_r || out_ready) begin
              out_status_r <= res_status;
              out_hop_r    <= res_hop;
              out_dev_r    <= res_dev;
              out_valid_r  <= 1'b1;
              state_r      <= S_IDLE;
            end else begin
              pend_status_r <= res_status;
              pend_hop_r    <= res_hop;
              pend_dev_r    <= res_dev;
              state_r       <= S_DRAIN;
            end
          end else if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_DRAIN: begin
          if (out_ready) begin
            out_status_r <= pend_status_r;
            out_hop_r    <= pend_hop_r;
            out_dev_r    <= pend_dev_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_next_hop = out_hop_r;
  assign out_device   = out_dev_r;

endmodule

[rtl/lprt_checker.sv]
// ---------------------------------------------------------------------------
// lprt_checker
// port-level checks of the route table, bound to the top level
// ---------------------------------------------------------------------------
`include "longest_prefix_route_table_unit_assert.svh"

module lprt_checker import lprt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_next_hop,
  input logic [3:0]  out_device
);

  logic res_fail, res_clear;

  assign res_fail  = out_valid && (out_status != ST_OK);
  assign res_clear = (out_next_hop == 32'd0) && (out_device == 4'd0);

  // a stalled result stays offered
  `LPRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped on stall")

  // one item at a time: busy right after an accept
  `LPRT_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "item taken while busy")

  `LPRT_ASSERT_SAME(a_status_range, out_valid, out_status <= ST_UNREACH, "bad status code")

  // failures carry no next hop and no device
  `LPRT_ASSERT_SAME(a_fail_zero, res_fail, res_clear, "failed item with nonzero fields")

endmodule

bind longest_prefix_route_table_unit lprt_checker u_lprt_checker (.*);
